// File: sv/bsf_pkg.sv
// bsf_pkg: shared constants, types and helper functions of the brush stamp frame store
// used by brush_stamp_framebuffer, bsf_ram instances and bsf_checker
// no dependencies
package bsf_pkg;

    localparam int FRAME_WIDTH  = 512;
    localparam int FRAME_HEIGHT = 512;
    localparam int MAX_BRUSH    = 128;

    localparam int FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int XW           = $clog2(FRAME_WIDTH);
    localparam int YW           = $clog2(FRAME_HEIGHT);
    localparam int PIX_AW       = $clog2(FRAME_PIXELS);

    localparam int POS_W        = 13;
    localparam int CW           = POS_W + 1;
    localparam int COLOR_W      = 24;
    localparam int SIZE_CFG_W   = 8;
    localparam int PIX_W        = COLOR_W + 1;

    localparam int SIZE_W       = $clog2(MAX_BRUSH + 1);
    localparam int OFF_W        = SIZE_W + 1;
    localparam int SQ_W         = 2 * SIZE_W;
    localparam int DIST_W       = SQ_W + 1;

    localparam int LFSR_W          = 16;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
    localparam int SPRAY_MODULUS   = 100;
    localparam int SPRAY_THRESHOLD = 90;
    localparam int SPRAY_RECIP     = 5243;
    localparam int SPRAY_SHIFT     = 19;
    localparam int PROD_W          = 32;
    localparam int QUOT_W          = 10;
    localparam int REM_W           = 17;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_IDX_W-1:0] REG_BRUSH_COLOR      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_COLOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRUSH_SIZE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_SHAPE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPRAY_MODE       = 3'd4;

    typedef enum logic [1:0] {
        OP_STAMP   = 2'd0,
        OP_CLEAR   = 2'd1,
        OP_REPAINT = 2'd2,
        OP_READ    = 2'd3
    } op_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               painted;
    } pixel_t;

    function automatic logic [XW-1:0] clamp_col(input logic signed [CW-1:0] v);
        logic [XW-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > CW'(FRAME_WIDTH - 1))
            r = XW'(FRAME_WIDTH - 1);
        else
            r = v[XW-1:0];
        return r;
    endfunction

    function automatic logic [YW-1:0] clamp_row(input logic signed [CW-1:0] v);
        logic [YW-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > CW'(FRAME_HEIGHT - 1))
            r = YW'(FRAME_HEIGHT - 1);
        else
            r = v[YW-1:0];
        return r;
    endfunction

    function automatic logic [PIX_AW-1:0] pixel_addr(input logic [XW-1:0] x,
                                                     input logic [YW-1:0] y);
        return PIX_AW'(y) * PIX_AW'(FRAME_WIDTH) + PIX_AW'(x);
    endfunction

    // fibonacci lfsr, taps 16 14 13 11
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] l);
        logic fb;
        fb = l[0] ^ l[2] ^ l[3] ^ l[5];
        return {fb, l[LFSR_W-1:1]};
    endfunction

endpackage

// File: sv/bsf_ram.sv
// bsf_ram: generic simple dual-port ram, one write port and one registered read port
// no dependencies
module bsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

// File: sv/brush_stamp_framebuffer.sv
// brush_stamp_framebuffer: painting engine over one frame store ram of color and mask bit
// depends on bsf_pkg and bsf_ram
//
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   operation, pos_x, pos_y
// m_axis    out  m_axis_tvalid/m_axis_tready   pixel_color, pixel_painted
// cfg       in   cfg_wr_en                     cfg_index, cfg_data
//
// stamp: one ram write per cycle sets it; size 1 writes the cursor pixel only
// clear and repaint: one sweep of the ram each
// read: through the registered ram read port
// after reset a clearing sweep over all FRAME_PIXELS runs with s_axis_tready low
// one item at a time; the next item is taken while a result still waits on m_axis
module brush_stamp_framebuffer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bsf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // operation, pos_x, pos_y
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [bsf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // pixel_color, pixel_painted
    input  logic                              cfg_wr_en,
    input  logic [bsf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bsf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    typedef enum logic [8:0] {
        ST_INIT    = 9'b000000001,
        ST_IDLE    = 9'b000000010,
        ST_CURSOR  = 9'b000000100,
        ST_STAMP   = 9'b000001000,
        ST_FILL    = 9'b000010000,
        ST_REPAINT = 9'b000100000,
        ST_READ    = 9'b001000000,
        ST_DRAIN   = 9'b010000000,
        ST_DONE    = 9'b100000000
    } state_t;

    // configuration
    logic [bsf_pkg::COLOR_W-1:0]    brush_color_reg;
    logic [bsf_pkg::COLOR_W-1:0]    background_color_reg;
    logic [bsf_pkg::SIZE_CFG_W-1:0] brush_size_reg;
    logic                           round_shape_reg;
    logic                           spray_mode_reg;

    // control
    state_t                         state_reg, state_next;
    logic [bsf_pkg::PIX_AW-1:0]     cnt_reg, cnt_next;
    logic [bsf_pkg::LFSR_W-1:0]     lfsr_reg, lfsr_next;
    logic                           st_valid_reg, st_valid_next;
    logic                           rp_valid_reg, rp_valid_next;
    logic                           m_valid_reg, m_valid_next;

    // payload
    bsf_pkg::op_t                   op_reg;
    logic signed [bsf_pkg::POS_W-1:0] pos_x_reg, pos_y_reg;
    logic [bsf_pkg::SIZE_W-1:0]     i_reg, i_next, j_reg, j_next;
    logic [bsf_pkg::SQ_W-1:0]       halfsq_reg, halfsq_next;
    logic [bsf_pkg::XW-1:0]         st_x_reg;
    logic [bsf_pkg::YW-1:0]         st_y_reg;
    logic [bsf_pkg::LFSR_W-1:0]     st_lfsr_reg;
    logic [bsf_pkg::QUOT_W-1:0]     st_quot_reg;
    logic [bsf_pkg::DIST_W-1:0]     st_dist_reg;
    logic [bsf_pkg::PIX_AW-1:0]     rp_addr_reg;
    bsf_pkg::pixel_t                m_data_reg, m_data_next;

    // datapath
    logic                           in_accept;
    bsf_pkg::op_t                   in_op;
    logic [bsf_pkg::SIZE_W-1:0]     eff_size, half;
    logic [bsf_pkg::PIX_AW-1:0]     cur_addr;
    logic                           cnt_last;
    logic signed [bsf_pkg::OFF_W-1:0] di, dj;
    logic [bsf_pkg::SIZE_W-1:0]     di_mag, dj_mag;
    logic signed [bsf_pkg::CW-1:0]  cand_x, cand_y;
    logic [bsf_pkg::DIST_W-1:0]     dist_sq;
    logic [bsf_pkg::LFSR_W-1:0]     lfsr_stepped;
    logic [bsf_pkg::PROD_W-1:0]     spray_prod;
    logic [bsf_pkg::REM_W-1:0]      spray_rem, spray_rem_fix;
    logic                           spray_keep, disc_keep, st_write, rp_write;

    // ram
    logic                           ram_wr_en, ram_rd_en;
    logic [bsf_pkg::PIX_AW-1:0]     ram_wr_addr, ram_rd_addr;
    bsf_pkg::pixel_t                ram_wr_data, ram_rd_data;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_op         = bsf_pkg::op_t'(s_axis_tdata[1:0]);

    always_comb
    begin
        if (int'(brush_size_reg) > bsf_pkg::MAX_BRUSH)
            eff_size = bsf_pkg::SIZE_W'(bsf_pkg::MAX_BRUSH);
        else
            eff_size = bsf_pkg::SIZE_W'(brush_size_reg);
    end

    assign half     = eff_size >> 1;
    assign cur_addr = bsf_pkg::pixel_addr(bsf_pkg::clamp_col(bsf_pkg::CW'(pos_x_reg)),
                                          bsf_pkg::clamp_row(bsf_pkg::CW'(pos_y_reg)));
    assign cnt_last = (cnt_reg == bsf_pkg::PIX_AW'(bsf_pkg::FRAME_PIXELS - 1));

    // candidate stage
    assign di     = $signed({1'b0, i_reg}) - $signed({1'b0, half});
    assign dj     = $signed({1'b0, j_reg}) - $signed({1'b0, half});
    assign di_mag = di[bsf_pkg::OFF_W-1] ? bsf_pkg::SIZE_W'(-di) : bsf_pkg::SIZE_W'(di);
    assign dj_mag = dj[bsf_pkg::OFF_W-1] ? bsf_pkg::SIZE_W'(-dj) : bsf_pkg::SIZE_W'(dj);
    assign cand_x = bsf_pkg::CW'(pos_x_reg) + bsf_pkg::CW'(di);
    assign cand_y = bsf_pkg::CW'(pos_y_reg) + bsf_pkg::CW'(dj);
    assign dist_sq = bsf_pkg::DIST_W'(bsf_pkg::SQ_W'(di_mag) * bsf_pkg::SQ_W'(di_mag))
                   + bsf_pkg::DIST_W'(bsf_pkg::SQ_W'(dj_mag) * bsf_pkg::SQ_W'(dj_mag));

    // quotient by 100 through the reciprocal, may be one too high
    assign lfsr_stepped = bsf_pkg::lfsr_step(lfsr_reg);
    assign spray_prod   = bsf_pkg::PROD_W'(lfsr_stepped) * bsf_pkg::PROD_W'(bsf_pkg::SPRAY_RECIP);

    // write stage
    assign spray_rem     = bsf_pkg::REM_W'(st_lfsr_reg)
                         - bsf_pkg::REM_W'(st_quot_reg) * bsf_pkg::REM_W'(bsf_pkg::SPRAY_MODULUS);
    assign spray_rem_fix = spray_rem[bsf_pkg::REM_W-1]
                         ? spray_rem + bsf_pkg::REM_W'(bsf_pkg::SPRAY_MODULUS) : spray_rem;
    assign spray_keep    = (spray_rem_fix >= bsf_pkg::REM_W'(bsf_pkg::SPRAY_THRESHOLD));
    assign disc_keep     = (st_dist_reg <= bsf_pkg::DIST_W'(halfsq_reg));
    assign st_write      = st_valid_reg && (!spray_mode_reg || spray_keep)
                         && (!round_shape_reg || disc_keep);
    assign rp_write      = rp_valid_reg && !ram_rd_data.painted;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        lfsr_next     = lfsr_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        halfsq_next   = halfsq_reg;
        st_valid_next = 1'b0;
        rp_valid_next = 1'b0;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_data_next   = m_data_reg;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = cur_addr;
        unique case (state_reg)
            ST_INIT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_accept)
                begin
                    unique case (in_op)
                        bsf_pkg::OP_STAMP:   state_next = ST_CURSOR;
                        bsf_pkg::OP_CLEAR:   state_next = ST_FILL;
                        bsf_pkg::OP_REPAINT: state_next = ST_REPAINT;
                        bsf_pkg::OP_READ:    state_next = ST_READ;
                    endcase
                end
            end
            ST_CURSOR:
            begin
                i_next      = '0;
                j_next      = '0;
                halfsq_next = bsf_pkg::SQ_W'(half) * bsf_pkg::SQ_W'(half);
                state_next  = (eff_size == bsf_pkg::SIZE_W'(1)) ? ST_DONE : ST_STAMP;
            end
            ST_STAMP:
            begin
                st_valid_next = 1'b1;
                if (spray_mode_reg)
                    lfsr_next = lfsr_stepped;
                if (j_reg == eff_size)
                begin
                    j_next = '0;
                    if (i_reg == eff_size)
                        state_next = ST_DRAIN;
                    else
                        i_next = i_reg + 1'b1;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_FILL:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_REPAINT:
            begin
                ram_rd_en     = 1'b1;
                ram_rd_addr   = cnt_reg;
                rp_valid_next = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_READ:
            begin
                ram_rd_en  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = (op_reg == bsf_pkg::OP_READ) ? ram_rd_data : '0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ram write port
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = cnt_reg;
        ram_wr_data = '{color: background_color_reg, painted: 1'b0};
        if (state_reg == ST_INIT)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_data = '0;
        end
        else if (state_reg == ST_FILL)
        begin
            ram_wr_en = 1'b1;
        end
        else if (state_reg == ST_CURSOR)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cur_addr;
            ram_wr_data = '{color: brush_color_reg, painted: 1'b1};
        end
        else if (st_write)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = bsf_pkg::pixel_addr(st_x_reg, st_y_reg);
            ram_wr_data = '{color: brush_color_reg, painted: 1'b1};
        end
        else if (rp_write)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = rp_addr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            cnt_reg      <= '0;
            lfsr_reg     <= bsf_pkg::LFSR_SEED;
            st_valid_reg <= 1'b0;
            rp_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            lfsr_reg     <= lfsr_next;
            st_valid_reg <= st_valid_next;
            rp_valid_reg <= rp_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brush_color_reg      <= 24'hFFFFFF;
            background_color_reg <= '0;
            brush_size_reg       <= 8'd1;
            round_shape_reg      <= 1'b0;
            spray_mode_reg       <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                bsf_pkg::REG_BRUSH_COLOR:      brush_color_reg      <= cfg_data;
                bsf_pkg::REG_BACKGROUND_COLOR: background_color_reg <= cfg_data;
                bsf_pkg::REG_BRUSH_SIZE:       brush_size_reg       <= cfg_data[7:0];
                bsf_pkg::REG_ROUND_SHAPE:      round_shape_reg      <= cfg_data[0];
                bsf_pkg::REG_SPRAY_MODE:       spray_mode_reg       <= cfg_data[0];
                default:                       ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg    <= in_op;
            pos_x_reg <= s_axis_tdata[14:2];
            pos_y_reg <= s_axis_tdata[27:15];
        end
        i_reg       <= i_next;
        j_reg       <= j_next;
        halfsq_reg  <= halfsq_next;
        st_x_reg    <= bsf_pkg::clamp_col(cand_x);
        st_y_reg    <= bsf_pkg::clamp_row(cand_y);
        st_lfsr_reg <= lfsr_stepped;
        st_quot_reg <= spray_prod[bsf_pkg::SPRAY_SHIFT +: bsf_pkg::QUOT_W];
        st_dist_reg <= dist_sq;
        rp_addr_reg <= cnt_reg;
        m_data_reg  <= m_data_next;
    end

    bsf_ram #(
        .WIDTH (bsf_pkg::PIX_W),
        .DEPTH (bsf_pkg::FRAME_PIXELS)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = bsf_pkg::OUT_TDATA_W'({m_data_reg.painted, m_data_reg.color});

endmodule

// File: sv/bsf_checker.sv
// bsf_checker: port-level assertions for brush_stamp_framebuffer, attached by bind
// depends on bsf_pkg
module bsf_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [bsf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata    // pixel_color, pixel_painted
);

    logic       in_acc, out_acc;
    logic [1:0] pend_reg;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // items taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_reg + 2'(in_acc) - 2'(out_acc);
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_axis_tready)
        else $error("input taken again right after an item");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pend_reg != 2'd0)
        else $error("result item without a pending input item");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two items in flight");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[bsf_pkg::OUT_TDATA_W-1:bsf_pkg::PIX_W] == '0)
        else $error("result padding bits not zero");

endmodule

bind brush_stamp_framebuffer bsf_checker u_bsf_checker (.*);

// File: tb/tb_brush_stamp_framebuffer.sv
`timescale 1ns / 1ps
// tb_brush_stamp_framebuffer: self-checking bench for the brush stamp frame store
// keeps its own copy of the picture, mask and spray lfsr and checks every result
// depends on bsf_pkg and brush_stamp_framebuffer
module tb_brush_stamp_framebuffer;
    import bsf_pkg::*;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 8;
    localparam int WATCHDOG_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES    = 32;
    localparam int REPORT_LIMIT    = 10;
    localparam int PLAN_LEN        = 44;
    localparam int POS_MIN         = -4096;
    localparam int POS_MAX         = 4095;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic                   is_write;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        op_t                    op;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic                   known;
        logic [COLOR_W-1:0]     rgb;
        logic                   painted;
    } plan_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;   // operation, pos_x, pos_y
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;        // pixel_color, pixel_painted
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    // predicted picture and register copies
    bit [COLOR_W-1:0]  picture_rgb [FRAME_PIXELS];
    bit                picture_mark [FRAME_PIXELS];
    bit [LFSR_W-1:0]   spray_reg = LFSR_SEED;
    bit [COLOR_W-1:0]  brush_rgb = 24'hFFFFFF;
    bit [COLOR_W-1:0]  bg_rgb = '0;
    bit [7:0]          brush_len = 8'd1;
    bit                round_on = 1'b0;
    bit                spray_on = 1'b0;

    pixel_t            readback_q [$];
    plan_row_t         plan [PLAN_LEN];

    int  mismatches = 0;
    int  results_checked = 0;
    int  stamps_sent = 0;
    int  reads_sent = 0;
    int  sweeps_sent = 0;
    int  quiet_cycles = 0;
    int  stall_left = 0;
    bit  steady = 1'b0;

    brush_stamp_framebuffer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int pixel_of(int x, int y);
        int cx, cy;
        cx = (x < 0) ? 0 : ((x > FRAME_WIDTH - 1) ? FRAME_WIDTH - 1 : x);
        cy = (y < 0) ? 0 : ((y > FRAME_HEIGHT - 1) ? FRAME_HEIGHT - 1 : y);
        return cy * FRAME_WIDTH + cx;
    endfunction

    function automatic void put_brush(int x, int y);
        int k;
        k = pixel_of(x, y);
        picture_rgb[k] = brush_rgb;
        picture_mark[k] = 1'b1;
    endfunction

    function automatic bit spray_hit();
        bit fb;
        fb = spray_reg[0] ^ spray_reg[2] ^ spray_reg[3] ^ spray_reg[5];
        spray_reg = {fb, spray_reg[LFSR_W-1:1]};
        return (int'(spray_reg) % SPRAY_MODULUS) >= SPRAY_THRESHOLD;
    endfunction

    function automatic void paint_stamp(int x, int y);
        int span, half, di, dj;
        span = (brush_len > MAX_BRUSH) ? MAX_BRUSH : int'(brush_len);
        put_brush(x, y);
        if (span == 1)
            return;
        half = span / 2;
        for (int i = 0; i <= span; i++)
            for (int j = 0; j <= span; j++)
            begin
                di = i - half;
                dj = j - half;
                // lfsr steps for every candidate, also ones the disc drops
                if (spray_on && !spray_hit())
                    continue;
                if (round_on && di * di + dj * dj > half * half)
                    continue;
                put_brush(x + di, y + dj);
            end
    endfunction

    function automatic pixel_t apply_item(op_t op, int x, int y);
        pixel_t res;
        int k;
        res = '0;
        case (op)
            OP_STAMP:
                paint_stamp(x, y);
            OP_CLEAR:
                for (int p = 0; p < FRAME_PIXELS; p++)
                begin
                    picture_rgb[p] = bg_rgb;
                    picture_mark[p] = 1'b0;
                end
            OP_REPAINT:
                for (int p = 0; p < FRAME_PIXELS; p++)
                    if (!picture_mark[p])
                        picture_rgb[p] = bg_rgb;
            default:
            begin
                k = pixel_of(x, y);
                res.color = picture_rgb[k];
                res.painted = picture_mark[k];
            end
        endcase
        return res;
    endfunction

    function automatic plan_row_t row_write(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] val);
        plan_row_t r;
        r = '0;
        r.is_write = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic plan_row_t row_item(op_t op, int x, int y);
        plan_row_t r;
        r = '0;
        r.op = op;
        r.pos_x = POS_W'(x);
        r.pos_y = POS_W'(y);
        return r;
    endfunction

    function automatic plan_row_t row_check(op_t op, int x, int y,
                                            logic [COLOR_W-1:0] rgb, logic painted);
        plan_row_t r;
        r = row_item(op, x, y);
        r.known = 1'b1;
        r.rgb = rgb;
        r.painted = painted;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int fit13(int v);
        return (v < POS_MIN) ? POS_MIN : ((v > POS_MAX) ? POS_MAX : v);
    endfunction

    function automatic int pick_pos(int extent);
        if ($urandom_range(0, 99) < 25)
            return int'($urandom_range(0, 8191)) + POS_MIN;
        return int'($urandom_range(0, extent + 15)) - 8;
    endfunction

    // all tasks below start and end right after a rising edge
    task automatic issue(op_t op, int x, int y, bit known,
                         logic [COLOR_W-1:0] rgb, logic painted);
        pixel_t want;
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata <= {4'b0, POS_W'(y), POS_W'(x), op};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        want = apply_item(op, x, y);
        if (known)
        begin
            want.color = rgb;
            want.painted = painted;
        end
        readback_q.push_back(want);
        case (op)
            OP_STAMP: stamps_sent++;
            OP_READ:  reads_sent++;
            default:  sweeps_sent++;
        endcase
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (readback_q.size() != 0 || !s_axis_tready)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_BRUSH_COLOR:      brush_rgb = val;
            REG_BACKGROUND_COLOR: bg_rgb = val;
            REG_BRUSH_SIZE:       brush_len = val[7:0];
            REG_ROUND_SHAPE:      round_on = val[0];
            REG_SPRAY_MODE:       spray_on = val[0];
            default:              ;
        endcase
    endtask

    // result sink with random stalls
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!steady && $urandom_range(0, 99) < 20)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                       : $urandom_range(10, 40);
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
        begin
            if (readback_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result %h with nothing expected", $realtime, m_axis_tdata);
            end
            else
            begin
                want = readback_q.pop_front();
                results_checked++;
                if (m_axis_tdata[COLOR_W-1:0] !== want.color
                    || m_axis_tdata[COLOR_W] !== want.painted)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result %0d expected rgb %06h painted %0b, got rgb %06h painted %0b",
                                 $realtime, results_checked, want.color, want.painted,
                                 m_axis_tdata[COLOR_W-1:0], m_axis_tdata[COLOR_W]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d cycles without an item moving", quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        int phase, sent, len, reach, cx, cy, n, r;
        logic [COLOR_W-1:0] rgb;

        plan = '{
            row_check(OP_READ,       0,     0, 24'h000000, 1'b0),
            row_check(OP_READ,   -4096,  4095, 24'h000000, 1'b0),
            row_check(OP_STAMP,      0,     0, 24'h000000, 1'b0),
            row_check(OP_READ,   -4096, -4096, 24'hFFFFFF, 1'b1),
            row_check(OP_STAMP,   4095,  4095, 24'h000000, 1'b0),
            row_check(OP_READ,     511,   511, 24'hFFFFFF, 1'b1),
            row_write(REG_BRUSH_COLOR, 24'h123456),
            row_write(REG_BRUSH_SIZE, 24'h000000),
            row_check(OP_STAMP,    100,   100, 24'h000000, 1'b0),
            row_check(OP_READ,     100,   100, 24'h123456, 1'b1),
            row_check(OP_READ,     101,   100, 24'h000000, 1'b0),
            row_write(REG_BACKGROUND_COLOR, 24'hFFFFFF),
            row_write(REG_BRUSH_COLOR, 24'h000000),
            row_check(OP_REPAINT,    0,     0, 24'h000000, 1'b0),
            row_check(OP_READ,       5,     5, 24'hFFFFFF, 1'b0),
            row_check(OP_READ,       0,     0, 24'hFFFFFF, 1'b1),
            row_check(OP_READ,     100,   100, 24'h123456, 1'b1),
            row_write(REG_BACKGROUND_COLOR, 24'h00FF00),
            row_check(OP_CLEAR,      0,     0, 24'h000000, 1'b0),
            row_check(OP_READ,       0,     0, 24'h00FF00, 1'b0),
            row_write(REG_BRUSH_COLOR, 24'hFF0000),
            row_write(REG_BRUSH_SIZE, 24'h0000FF),
            row_write(REG_ROUND_SHAPE, 24'h000001),
            row_check(OP_STAMP,    256,   256, 24'h000000, 1'b0),
            row_check(OP_READ,     320,   256, 24'hFF0000, 1'b1),
            row_check(OP_READ,     320,   320, 24'h00FF00, 1'b0),
            row_write(REG_ROUND_SHAPE, 24'h000000),
            row_write(REG_BRUSH_SIZE, 24'h000080),
            row_check(OP_STAMP,  -4096, -4096, 24'h000000, 1'b0),
            row_check(OP_READ,       0,     0, 24'hFF0000, 1'b1),
            row_write(REG_BRUSH_COLOR, 24'h0000FF),
            row_write(REG_BRUSH_SIZE, 24'h000008),
            row_write(REG_SPRAY_MODE, 24'h000001),
            row_check(OP_STAMP,    200,   200, 24'h000000, 1'b0),
            row_check(OP_READ,     200,   200, 24'h0000FF, 1'b1),
            row_item(OP_READ,      203,   198),
            row_write(REG_SPARE_A, 24'hFFFFFF),
            row_write(REG_SPARE_B, 24'h000000),
            row_write(REG_SPRAY_MODE, 24'h000000),
            row_write(REG_ROUND_SHAPE, 24'h000001),
            row_write(REG_BRUSH_SIZE, 24'h000002),
            row_check(OP_STAMP,    300,   300, 24'h000000, 1'b0),
            row_item(OP_READ,      301,   301),
            row_item(OP_READ,      301,   300)
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_write)
            begin
                wait_idle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
                issue(plan[i].op, plan[i].pos_x, plan[i].pos_y, plan[i].known,
                      plan[i].rgb, plan[i].painted);
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            steady <= (phase % 4 == 2);
            if (phase == 0)
                rgb = 24'hFFFFFF;
            else if (phase == 1)
                rgb = 24'h000000;
            else
                rgb = COLOR_W'($urandom);
            write_reg(REG_BRUSH_COLOR, rgb);
            write_reg(REG_BACKGROUND_COLOR, (phase == 1) ? 24'h000000 : COLOR_W'($urandom));
            if (phase == 3)
                len = $urandom_range(0, 1) ? MAX_BRUSH : $urandom_range(MAX_BRUSH + 1, 255);
            else if (phase == 5)
                len = 1;
            else if ($urandom_range(0, 99) < 15)
                len = $urandom_range(0, 1);
            else
                len = $urandom_range(2, 16);
            // upper bits of the narrow registers must be ignored
            write_reg(REG_BRUSH_SIZE, {16'($urandom), 8'(len)});
            write_reg(REG_ROUND_SHAPE, {23'($urandom), 1'($urandom)});
            write_reg(REG_SPRAY_MODE, {23'($urandom), 1'($urandom)});
            reach = ((len > MAX_BRUSH) ? MAX_BRUSH : len) / 2 + 2;

            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    // stamp, then look around it
                    cx = pick_pos(FRAME_WIDTH);
                    cy = pick_pos(FRAME_HEIGHT);
                    issue(OP_STAMP, cx, cy, 1'b0, '0, 1'b0);
                    n = $urandom_range(2, 4);
                    repeat (n)
                        issue(OP_READ,
                              fit13(cx + int'($urandom_range(0, 2 * reach)) - reach),
                              fit13(cy + int'($urandom_range(0, 2 * reach)) - reach),
                              1'b0, '0, 1'b0);
                    sent += n + 1;
                end
                else if (r < 85)
                begin
                    issue(OP_READ, pick_pos(FRAME_WIDTH), pick_pos(FRAME_HEIGHT),
                          1'b0, '0, 1'b0);
                    sent++;
                end
                else
                begin
                    issue(OP_STAMP, int'($urandom_range(0, 8191)) + POS_MIN,
                          int'($urandom_range(0, 8191)) + POS_MIN, 1'b0, '0, 1'b0);
                    sent++;
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (readback_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d stamps, %0d reads, %0d clear/repaint sweeps over %0d random phases",
                 stamps_sent, reads_sent, sweeps_sent, PHASES);
        $display("checked %0d results, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
